@@ hdl/hrfp_pkg.sv @@
// Shared types, constants and helpers for the hex text ranging frame parser.
package hrfp_pkg;

    localparam int FRAME_LEN_DEF = 64;
    localparam int Q_DEPTH       = 2;
    localparam int POS_W         = 7;
    localparam int NFIELDS       = 8;
    localparam int NSPACES       = 9;

    localparam logic [7:0] HDR_M    = 8'h6D;
    localparam logic [7:0] HDR_C    = 8'h63;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [POS_W-1:0] COLON_POS = 7'd61;
    localparam logic [POS_W-1:0] HDR_C_POS = 7'd1;

    localparam logic [7:0] MASK_THREE = 8'h07;
    localparam logic [7:0] MASK_FOUR  = 8'h0F;

    localparam logic [POS_W-1:0] FLD_START [NFIELDS] =
        '{7'd3, 7'd6, 7'd15, 7'd24, 7'd33, 7'd42, 7'd47, 7'd50};
    localparam logic [POS_W-1:0] FLD_END [NFIELDS] =
        '{7'd5, 7'd14, 7'd23, 7'd32, 7'd41, 7'd46, 7'd49, 7'd58};
    localparam logic [POS_W-1:0] SPACE_POS [NSPACES] =
        '{7'd2, 7'd5, 7'd14, 7'd23, 7'd32, 7'd41, 7'd46, 7'd49, 7'd58};

    // field indexes
    localparam int F_MASK  = 0;
    localparam int F_R0    = 1;
    localparam int F_R1    = 2;
    localparam int F_R2    = 3;
    localparam int F_R3    = 4;
    localparam int F_COUNT = 5;
    localparam int F_SEQ   = 6;
    localparam int F_DEBUG = 7;

    typedef enum logic [1:0] {
        FS_EMPTY   = 2'd0,
        FS_DIGITS  = 2'd1,
        FS_CLOSED  = 2'd2,
        FS_NODIGIT = 2'd3
    } field_st_t;

    // one queue entry: a frame opener or a frame byte
    typedef struct packed {
        logic             open;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } item_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b0;
        r.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok = 1'b1;
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic logic is_space_pos(input logic [POS_W-1:0] p);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NSPACES; k++) begin
            if (p == SPACE_POS[k]) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

@@ hdl/hrfp_front.sv @@
// Front end: header hunt, frame position count and classification of each byte.
module hrfp_front #(
    parameter int FRAME_LEN = hrfp_pkg::FRAME_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                push,
    output hrfp_pkg::item_t     push_item,
    input  logic                q_full
);

    localparam logic [hrfp_pkg::POS_W-1:0] LAST_POS = hrfp_pkg::POS_W'(FRAME_LEN - 1);

    logic                        hunting_reg, hunting_next;
    logic [7:0]                  prev_reg, prev_next;
    logic [hrfp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    always_comb begin
        hunting_next   = hunting_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        push           = 1'b0;
        push_item.open = 1'b0;
        push_item.last = 1'b0;
        push_item.pos  = pos_reg;
        push_item.data = s_rx_byte;
        if (take) begin
            if (hunting_reg) begin
                prev_next = s_rx_byte;
                if (prev_reg == hrfp_pkg::HDR_M && s_rx_byte == hrfp_pkg::HDR_C) begin
                    push           = 1'b1;
                    push_item.open = 1'b1;
                    push_item.pos  = hrfp_pkg::HDR_C_POS;
                    hunting_next   = 1'b0;
                    pos_next       = hrfp_pkg::HDR_C_POS + 1'b1;
                end
            end else begin
                push = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_POS) begin
                    push_item.last = 1'b1;
                    hunting_next   = 1'b1;
                    prev_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunting_reg <= 1'b1;
            prev_reg    <= '0;
            pos_reg     <= '0;
        end else begin
            hunting_reg <= hunting_next;
            prev_reg    <= prev_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

@@ hdl/hrfp_queue.sv @@
// Short register queue between the front end and the field engine.
module hrfp_queue #(
    parameter int DEPTH = hrfp_pkg::Q_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hrfp_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output hrfp_pkg::item_t  head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    hrfp_pkg::item_t  mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1;
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

@@ hdl/hrfp_back.sv @@
// Field engine: delimiter check, hex field accumulation, held values and result register.
module hrfp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  hrfp_pkg::item_t  q_head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_frame_valid,
    output logic [7:0]       m_anchor_mask,
    output logic [31:0]      m_range_a0,
    output logic [31:0]      m_range_a1,
    output logic [31:0]      m_range_a2,
    output logic [31:0]      m_range_a3,
    output logic [15:0]      m_range_count,
    output logic [7:0]       m_sequence_no,
    output logic [31:0]      m_debug_word,
    output logic [3:0]       m_anchors_seen,
    output logic             m_fix_usable
);

    localparam int NF = hrfp_pkg::NFIELDS;

    logic [31:0]          accum_reg [NF];
    logic [31:0]          accum_next [NF];
    hrfp_pkg::field_st_t  st_reg [NF];
    hrfp_pkg::field_st_t  st_next [NF];
    logic [31:0]          held_reg [NF];
    logic [31:0]          held_next [NF];
    logic                 ok_reg, ok_next;
    logic                 mvalid_reg;
    hrfp_pkg::hex_t       hx;
    logic                 emit;
    logic [3:0]           pop_cnt;

    assign m_valid = mvalid_reg;
    assign pop     = !q_empty && (!q_head.last || !mvalid_reg || m_ready);
    assign emit    = pop && q_head.last;

    always_comb begin
        hx      = hrfp_pkg::hex_decode(q_head.data);
        ok_next = ok_reg;
        for (int f = 0; f < NF; f++) begin
            accum_next[f] = accum_reg[f];
            st_next[f]    = st_reg[f];
            held_next[f]  = held_reg[f];
        end
        if (q_head.open) begin
            ok_next = 1'b1;
            for (int f = 0; f < NF; f++) begin
                accum_next[f] = '0;
                st_next[f]    = hrfp_pkg::FS_EMPTY;
            end
        end else begin
            if (hrfp_pkg::is_space_pos(q_head.pos) && q_head.data != hrfp_pkg::CH_SPACE)
                ok_next = 1'b0;
            if (q_head.pos == hrfp_pkg::COLON_POS && q_head.data != hrfp_pkg::CH_COLON)
                ok_next = 1'b0;
            for (int f = 0; f < NF; f++) begin
                if (q_head.pos >= hrfp_pkg::FLD_START[f] && q_head.pos < hrfp_pkg::FLD_END[f]
                    && (st_reg[f] == hrfp_pkg::FS_EMPTY || st_reg[f] == hrfp_pkg::FS_DIGITS))
                begin
                    if (hx.ok) begin
                        accum_next[f] = {accum_reg[f][27:0], hx.val};
                        st_next[f]    = hrfp_pkg::FS_DIGITS;
                    end else begin
                        st_next[f] = (st_reg[f] == hrfp_pkg::FS_DIGITS) ?
                                     hrfp_pkg::FS_CLOSED : hrfp_pkg::FS_NODIGIT;
                    end
                end
            end
            // a good frame takes every field that saw at least one digit
            if (q_head.last && ok_next) begin
                for (int f = 0; f < NF; f++) begin
                    if (st_next[f] == hrfp_pkg::FS_DIGITS || st_next[f] == hrfp_pkg::FS_CLOSED)
                        held_next[f] = accum_next[f];
                end
            end
        end
        pop_cnt = '0;
        for (int b = 0; b < 8; b++) pop_cnt = pop_cnt + {3'b000, held_next[hrfp_pkg::F_MASK][b]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg     <= 1'b1;
            mvalid_reg <= 1'b0;
            for (int f = 0; f < NF; f++) begin
                accum_reg[f] <= '0;
                st_reg[f]    <= hrfp_pkg::FS_EMPTY;
                held_reg[f]  <= '0;
            end
        end else begin
            if (pop) begin
                ok_reg <= ok_next;
                for (int f = 0; f < NF; f++) begin
                    accum_reg[f] <= accum_next[f];
                    st_reg[f]    <= st_next[f];
                    held_reg[f]  <= held_next[f];
                end
            end
            if (emit)         mvalid_reg <= 1'b1;
            else if (m_ready) mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_frame_valid  <= ok_next;
            m_anchor_mask  <= held_next[hrfp_pkg::F_MASK][7:0];
            m_range_a0     <= held_next[hrfp_pkg::F_R0];
            m_range_a1     <= held_next[hrfp_pkg::F_R1];
            m_range_a2     <= held_next[hrfp_pkg::F_R2];
            m_range_a3     <= held_next[hrfp_pkg::F_R3];
            m_range_count  <= held_next[hrfp_pkg::F_COUNT][15:0];
            m_sequence_no  <= held_next[hrfp_pkg::F_SEQ][7:0];
            m_debug_word   <= held_next[hrfp_pkg::F_DEBUG];
            m_anchors_seen <= pop_cnt;
            m_fix_usable   <= (held_next[hrfp_pkg::F_MASK][7:0] == hrfp_pkg::MASK_THREE) ||
                              (held_next[hrfp_pkg::F_MASK][7:0] == hrfp_pkg::MASK_FOUR);
        end
    end

endmodule

@@ hdl/hex_text_ranging_frame_parser.sv @@
// Top level of the hex text ranging frame parser.
//
// Input channel (s_valid/s_ready, s_rx_byte): one received ASCII byte per
// transfer. The front end hunts for the two-byte header "mc"; it opens a frame
// of FRAME_LEN bytes counted from the 'm'. Outside a frame, bytes are consumed
// and dropped.
// Result channel (m_valid/m_ready): one transfer per completed frame carrying
// frame_valid (all delimiters matched), the held hex fields, the anchor count
// and the usable flag. Fields with no leading hex digit keep their old value.
// Throughput: one byte per cycle while the queue is not full. The front end
// classifies a byte straight into the queue register; the field engine takes it
// from the queue head, and m_valid rises in the cycle after it pops the last byte.
// Stalls: a result waits in the output register while the next frame's bytes
// keep flowing through the QUEUE_DEPTH entry queue; s_ready drops only when the
// last byte of a further frame reaches the engine with the previous result
// still untaken.
// Reset (aresetn, synchronous, active low): hunting, header window cleared,
// held fields zero, queue and output register empty.
module hex_text_ranging_frame_parser #(
    parameter int FRAME_LEN   = hrfp_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = hrfp_pkg::Q_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_valid,
    output logic [7:0]  m_anchor_mask,
    output logic [31:0] m_range_a0,
    output logic [31:0] m_range_a1,
    output logic [31:0] m_range_a2,
    output logic [31:0] m_range_a3,
    output logic [15:0] m_range_count,
    output logic [7:0]  m_sequence_no,
    output logic [31:0] m_debug_word,
    output logic [3:0]  m_anchors_seen,
    output logic        m_fix_usable
);

    logic             push, q_full, q_empty, pop;
    hrfp_pkg::item_t  push_item, q_head;

    hrfp_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    hrfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    hrfp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_valid  (m_frame_valid),
        .m_anchor_mask  (m_anchor_mask),
        .m_range_a0     (m_range_a0),
        .m_range_a1     (m_range_a1),
        .m_range_a2     (m_range_a2),
        .m_range_a3     (m_range_a3),
        .m_range_count  (m_range_count),
        .m_sequence_no  (m_sequence_no),
        .m_debug_word   (m_debug_word),
        .m_anchors_seen (m_anchors_seen),
        .m_fix_usable   (m_fix_usable)
    );

endmodule
